>>> rtl/tks_pkg.sv
// Shared types and constants for the top-k score selector.
// No dependencies; imported by tks_cell and top_k_score_selector_top.
package tks_pkg;

  // Default depth of the kept-row chain
  localparam int K_MAX_DEF = 16;
  // Most results emitted per data set (rank is 4 bits)
  localparam int MAX_OUT = 16;

  localparam int SCORE_W = 32;
  localparam int ID_W = 20;
  localparam int RANK_W = 4;
  localparam int RC_W = 5;

  // Register map
  localparam logic REG_RESULT_COUNT = 1'b0;
  localparam logic [RC_W-1:0] RESULT_COUNT_RST = 5'd10;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0] row_id;
    logic last_row;
  } tks_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] best_score;
    logic [ID_W-1:0] best_id;
    logic [RANK_W-1:0] rank;
    logic last_result;
  } tks_out_t;

  // One kept entry of the chain
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0] row_id;
  } kept_row_t;

  // Chain control, broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

>>> rtl/top_k_score_selector_top.sv
// Top level of the top-k score selector: APB register, chain of tks_cell
// and the drain sequencer. Depends on tks_pkg and tks_cell.
//
// Usage:
//   Rows enter on item with start; a row is taken when start is high and
//   busy is low. Each row is placed into a sorted chain of K_MAX cells in
//   the cycle it is taken, so rows not marked last go in one per cycle.
//   On a row marked last_row the row is inserted, busy rises, and the best
//   min(result_count, rows kept, 16) rows come out on result, best first,
//   one per cycle starting the cycle after the transfer, each marked by
//   result_strobe; the final one carries last_result. The chain drains
//   toward cell 0 one step per cycle, so after a last row busy stays high
//   while the results come out, and the next row can follow right after the
//   final result (with no gap at all when nothing is emitted).
//   The receiver cannot stall: each result is valid for exactly one cycle.
//   result_count is written over APB at address 0; the user must do this
//   only while idle, unchecked by the block. Reset (rst, synchronous)
//   empties the chain, sets result_count to 10; no clearing pass is needed.
module top_k_score_selector_top import tks_pkg::*; #(
  parameter int K_MAX = K_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // row channel
  input  logic        start,
  output logic        busy,
  input  tks_in_t     item,
  // result channel
  output logic        result_strobe,
  output tks_out_t    result,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(K_MAX + 1);
  localparam int NW = (CW > RC_W) ? CW : RC_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [RC_W-1:0] result_count;
  logic [RC_W-1:0] total;
  logic [RANK_W-1:0] rank;

  logic accept;
  logic is_last;
  logic [CW-1:0] count_after;
  logic [NW-1:0] n_min;
  cell_ctrl_t ctrl;
  kept_row_t new_row;
  kept_row_t rows [K_MAX];
  logic keeps [K_MAX];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESULT_COUNT) ? 32'(result_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_count <= RESULT_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RESULT_COUNT) begin
      result_count <= pwdata[RC_W-1:0];
    end
  end

  // Row transfer and chain control
  assign busy = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign ctrl.insert = accept;
  assign ctrl.drain = busy;
  assign new_row.score = item.score;
  assign new_row.row_id = item.row_id;

  // Number of rows to emit once the last row is in
  assign count_after = (count < CW'(K_MAX)) ? count + CW'(1) : count;
  always_comb begin
    n_min = NW'(result_count);
    if (NW'(count_after) < n_min) begin
      n_min = NW'(count_after);
    end
    if (NW'(MAX_OUT) < n_min) begin
      n_min = NW'(MAX_OUT);
    end
  end

  // Cell chain
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    kept_row_t prev_row;
    kept_row_t next_row;
    logic prev_keep;
    if (i == 0) begin : g_head
      assign prev_row = new_row;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_row = rows[i-1];
      assign prev_keep = keeps[i-1];
    end
    if (i == K_MAX - 1) begin : g_tail
      assign next_row = rows[i];
    end else begin : g_inner
      assign next_row = rows[i+1];
    end
    tks_cell #(.K_MAX(K_MAX), .IDX(i)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count),
      .new_row  (new_row),
      .prev_row (prev_row),
      .prev_keep(prev_keep),
      .next_row (next_row),
      .row      (rows[i]),
      .keep     (keeps[i])
    );
  end

  // Drain sequencer
  assign is_last = ({1'b0, rank} + 5'd1) == total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      total <= '0;
      rank <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rank <= '0;
            total <= RC_W'(n_min);
            if (!item.last_row) begin
              count <= count_after;
            end else if (n_min == '0) begin
              count <= '0;
            end else begin
              count <= count_after;
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          rank <= rank + RANK_W'(1);
          if (is_last) begin
            count <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result port, straight from cell 0
  assign result_strobe = busy;
  assign result.best_score = rows[0].score;
  assign result.best_id = rows[0].row_id;
  assign result.rank = rank;
  assign result.last_result = busy && is_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(K_MAX))
    else $error("kept count above chain depth");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_result |=> !busy)
    else $error("drain continued after last result");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> (total != '0) && (rank == '0))
    else $error("drain started with nothing to emit");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ({1'b0, rank} < total))
    else $error("rank beyond result total");

endmodule

>>> rtl/tks_cell.sv
// One cell of the sorted kept-row chain: holds a row, compares it with the
// incoming row and takes data from its neighbors. Depends on tks_pkg.
module tks_cell import tks_pkg::*; #(
  parameter int K_MAX = K_MAX_DEF,
  parameter int IDX = 0,
  localparam int CW = $clog2(K_MAX + 1)
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [CW-1:0] count,
  input  kept_row_t  new_row,
  input  kept_row_t  prev_row,
  input  logic       prev_keep,
  input  kept_row_t  next_row,
  output kept_row_t  row,
  output logic       keep
);

  logic occupied;

  // An occupied cell keeps its place when its score is not below the new one
  assign occupied = CW'(IDX) < count;
  assign keep = occupied && (row.score >= new_row.score);

  // Insert: hold, take the new row, or shift down from the previous cell.
  // Drain: shift up toward cell 0.
  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      row <= next_row;
    end else if (ctrl.insert && !keep) begin
      if (prev_keep) begin
        row <= new_row;
      end else begin
        row <= prev_row;
      end
    end
  end

endmodule
